### hdl/pic_pkg.sv
// ----------------------------------------------------------------------------
// pic_pkg - shared types and constants for the clamped-integrator PI core
// Register map, configuration bundle, product bundle and the fixed constants
// used by the error scaling (x100 / 7) path.
// ----------------------------------------------------------------------------
package pic_pkg;

  localparam int unsigned ValW    = 16;  // Q8.8 sample / gain / drive width
  localparam int unsigned LimW    = 32;  // integrator limit / accumulator width
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned MagW    = 23;  // |diff| * 100 fits in 23 bits
  localparam int unsigned QuoW    = 20;  // |diff| * 100 / 7 fits in 20 bits
  localparam int unsigned ErrW    = QuoW + 1;
  localparam int unsigned PPropW  = ErrW + ValW;  // error * prop_gain
  localparam int unsigned PIntW   = LimW + ValW;  // accumulator * integ_gain

  // Reciprocal of 7: floor(n * DivMul / 2^DivShift) == n / 7 for n < 2^24
  localparam int unsigned DivMulW  = 24;
  localparam logic [DivMulW-1:0] DivMul = 24'd9586981;
  localparam int unsigned DivShift = 26;

  // Largest error magnitude: 65535 * 100 / 7
  localparam int ErrMax = 936214;

  typedef enum logic [CfgIdxW-1:0] {
    REG_PROP_GAIN   = 3'd0,
    REG_INTEG_GAIN  = 3'd1,
    REG_INTEG_UPPER = 3'd2,
    REG_INTEG_LOWER = 3'd3,
    REG_OUT_UPPER   = 3'd4,
    REG_OUT_LOWER   = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic signed [ValW-1:0] prop_gain;
    logic signed [ValW-1:0] integ_gain;
    logic signed [LimW-1:0] integ_upper;
    logic signed [LimW-1:0] integ_lower;
    logic signed [ValW-1:0] out_upper;
    logic signed [ValW-1:0] out_lower;
  } cfg_t;

  localparam cfg_t CfgReset = '{
    prop_gain:   16'sd256,
    integ_gain:  16'sd0,
    integ_upper: 32'sh7FFF_FFFF,
    integ_lower: 32'sh8000_0000,
    out_upper:   16'sd25600,
    out_lower:   16'sd0
  };

  typedef struct packed {
    logic signed [PPropW-1:0] prop_prod;
    logic signed [PIntW-1:0]  integ_prod;
  } prod_t;

endpackage

### hdl/pic_drive_sum.sv
// ----------------------------------------------------------------------------
// pic_drive_sum - drive output combiner
// Scales both PI products down by 256 (floor), adds them and clamps the sum
// to the configured drive limits, upper limit checked first.
// ----------------------------------------------------------------------------
module pic_drive_sum import pic_pkg::*; (
  input  prod_t                  prod_i,
  input  cfg_t                   cfg_i,
  output logic signed [ValW-1:0] drive_o
);

  localparam int unsigned SumW = PIntW + 1;

  logic signed [PPropW-1:0] prop_sh;
  logic signed [PIntW-1:0]  integ_sh;
  logic signed [SumW-1:0]   sum;
  logic signed [SumW-1:0]   upper_x;
  logic signed [SumW-1:0]   lower_x;

  // Arithmetic shift right is floor division by 256
  assign prop_sh  = prod_i.prop_prod >>> 8;
  assign integ_sh = prod_i.integ_prod >>> 8;

  assign sum = SumW'(prop_sh) + SumW'(integ_sh);
  assign upper_x = SumW'(cfg_i.out_upper);
  assign lower_x = SumW'(cfg_i.out_lower);

  always_comb begin
    if (sum > upper_x) begin
      drive_o = cfg_i.out_upper;
    end else if (sum < lower_x) begin
      drive_o = cfg_i.out_lower;
    end else begin
      drive_o = sum[ValW-1:0];
    end
  end

endmodule

### hdl/pi_controller_clamped_integrator_core.sv
// ----------------------------------------------------------------------------
// pi_controller_clamped_integrator_core - PI controller, clamped integrator
// Takes position / setpoint beats, scales the error by 100/7, accumulates it
// with anti-windup clamping and emits a clamped Q8.8 drive per beat.
// ----------------------------------------------------------------------------
// Throughput: one beat per cycle while m_axis_tready is high; each stage
//   holds one item and moves on as soon as the stage after it is free, so
//   bubbles collapse under stalls.
// Five stages: scale by 100, multiply by 1/7, integrate and clamp, the two
//   gain multiplies, and sum / clamp into the output register.
// Reset: rst_ni clears all valid bits, target, measured and accumulator, and
//   loads the register defaults; no clearing pass is needed.
module pi_controller_clamped_integrator_core import pic_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // configuration write port
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [LimW-1:0]     cfg_wdata_i,
  // input stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [ValW-1:0]     s_axis_tdata,   // [15:0] value
  input  logic [0:0]          s_axis_tuser,   // [0] action (1 = new setpoint)
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [23:0]         m_axis_tdata    // [15:0] drive, [16] integ_clamped
);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_wdata_i[ValW-1:0];
        REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_wdata_i[ValW-1:0];
        REG_INTEG_UPPER: cfg_q.integ_upper <= cfg_wdata_i;
        REG_INTEG_LOWER: cfg_q.integ_lower <= cfg_wdata_i;
        REG_OUT_UPPER:   cfg_q.out_upper   <= cfg_wdata_i[ValW-1:0];
        REG_OUT_LOWER:   cfg_q.out_lower   <= cfg_wdata_i[ValW-1:0];
        default: ;  // unmapped index: drop the write
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage occupancy and flow control: a stage loads when it is empty or when
  // its own content moves on in the same cycle.
  // --------------------------------------------------------------------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5;
  logic ld1, ld2, ld3, ld4, ld5;

  assign rdy5 = !v5_q || m_axis_tready;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;

  assign ld1 = rdy1 && s_axis_tvalid;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign ld4 = rdy4 && v3_q;
  assign ld5 = rdy5 && v4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: update target / measured, form |target - measured| * 100
  // --------------------------------------------------------------------------
  logic signed [ValW-1:0] target_q, measured_q;
  logic signed [ValW-1:0] target_d, measured_d;
  logic signed [ValW:0]   diff;
  logic [ValW-1:0]        diff_mag;
  logic [MagW-1:0]        mag100;
  logic [MagW-1:0]        mag1_q;
  logic                   neg1_q, clr1_q;

  always_comb begin
    target_d   = target_q;
    measured_d = measured_q;
    if (s_axis_tuser[0]) begin
      target_d = s_axis_tdata;
    end else begin
      measured_d = s_axis_tdata;
    end
  end

  assign diff     = (ValW+1)'(target_d) - (ValW+1)'(measured_d);
  assign diff_mag = diff[ValW] ? ValW'(-diff) : diff[ValW-1:0];
  // x100 = x64 + x32 + x4
  assign mag100   = (MagW'(diff_mag) << 6) + (MagW'(diff_mag) << 5)
                  + (MagW'(diff_mag) << 2);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q   <= '0;
      measured_q <= '0;
    end else if (ld1) begin
      target_q   <= target_d;
      measured_q <= measured_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      mag1_q <= mag100;
      neg1_q <= diff[ValW];
      clr1_q <= s_axis_tuser[0];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: divide by 7 through the reciprocal multiply
  // --------------------------------------------------------------------------
  localparam int unsigned DivProdW = MagW + DivMulW;

  logic [DivProdW-1:0] div_prod;
  logic [QuoW-1:0]     quo2_q;
  logic                neg2_q, clr2_q;

  assign div_prod = DivProdW'(mag1_q) * DivProdW'(DivMul);

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      quo2_q <= div_prod[DivShift +: QuoW];
      neg2_q <= neg1_q;
      clr2_q <= clr1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: restore the sign (truncation toward zero), integrate and clamp.
  // acc3_q is the controller's accumulator; it only moves when an item loads.
  // --------------------------------------------------------------------------
  localparam int unsigned AccSumW = LimW + 1;

  logic signed [ErrW-1:0]    err;
  logic signed [LimW-1:0]    acc_base;
  logic signed [AccSumW-1:0] acc_sum;
  logic signed [LimW-1:0]    acc_d;
  logic                      clamp_d;
  logic signed [ErrW-1:0]    err3_q;
  logic signed [LimW-1:0]    acc3_q;
  logic                      clamp3_q;

  assign err      = neg2_q ? -$signed({1'b0, quo2_q}) : $signed({1'b0, quo2_q});
  // a setpoint beat clears the integrator before the error goes in
  assign acc_base = clr2_q ? '0 : acc3_q;
  assign acc_sum  = AccSumW'(acc_base) + AccSumW'(err);

  always_comb begin
    clamp_d = 1'b1;
    if (acc_sum > AccSumW'(cfg_q.integ_upper)) begin
      acc_d = cfg_q.integ_upper;
    end else if (acc_sum < AccSumW'(cfg_q.integ_lower)) begin
      acc_d = cfg_q.integ_lower;
    end else begin
      acc_d   = acc_sum[LimW-1:0];
      clamp_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc3_q <= '0;
    end else if (ld3) begin
      acc3_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      err3_q   <= err;
      clamp3_q <= clamp_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: gain multiplies
  // --------------------------------------------------------------------------
  prod_t prod4_q;
  logic  clamp4_q;

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      prod4_q.prop_prod  <= PPropW'(err3_q) * PPropW'(cfg_q.prop_gain);
      prod4_q.integ_prod <= PIntW'(acc3_q) * PIntW'(cfg_q.integ_gain);
      clamp4_q           <= clamp3_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5: combine, clamp to drive limits, hold in the output register
  // --------------------------------------------------------------------------
  logic signed [ValW-1:0] drive;
  logic signed [ValW-1:0] drive5_q;
  logic                   clamp5_q;

  pic_drive_sum u_drive_sum (
    .prod_i  (prod4_q),
    .cfg_i   (cfg_q),
    .drive_o (drive)
  );

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      drive5_q <= drive;
      clamp5_q <= clamp4_q;
    end
  end

  assign m_axis_tvalid = v5_q;
  assign m_axis_tdata  = {7'd0, clamp5_q, drive5_q};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  // The scaled error never leaves the range reachable from 16-bit operands
  a_err_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (err3_q <= ErrW'(ErrMax)) && (err3_q >= -ErrW'(ErrMax)))
    else $error("scaled error out of range");

  // A clamp flag means the accumulator sits on one of the limits
  a_clamp_on_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && clamp3_q |-> (acc3_q == cfg_q.integ_upper) ||
                         (acc3_q == cfg_q.integ_lower))
    else $error("clamp flag set but accumulator not on a limit");

  // With ordered limits the drive stays inside them
  a_drive_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (cfg_q.out_lower <= cfg_q.out_upper) |->
      (drive5_q <= cfg_q.out_upper) && (drive5_q >= cfg_q.out_lower))
    else $error("drive outside configured limits");

  // A stalled output holds its result
  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed under back-pressure");

endmodule
